// ===== rtl/core/minjs_pkg.sv =====
// Shared types and constants for the JavaScript minifier.
package minjs_pkg;

  // Most characters that one source byte can release
  localparam int unsigned MaxEmit = 4;

  // Group of characters released by one source byte, handed from front to back
  typedef struct packed {
    logic [3:0][7:0] bytes;  // released characters, entry 0 first
    logic [2:0]      count;  // number of valid entries, 0 to 4
    logic            last;   // group closes the stream
    logic            err;    // sticky error after this source byte
  } bundle_t;

  // One output item as it leaves the back end
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       stream_end;
    logic       err;
  } result_t;

endpackage

// ===== rtl/core/minjs_front.sv =====
// Front end: scanner that classifies each source byte and collects released characters.
module minjs_front
  import minjs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       push_valid_o,
  input  logic       push_ready_i,
  output bundle_t    push_data_o
);

  typedef enum logic [3:0] {
    ModeFetch  = 4'd0,
    ModeSlash  = 4'd1,
    ModeLine   = 4'd2,
    ModeBlock  = 4'd3,
    ModeBstar  = 4'd4,
    ModeQuote  = 4'd5,
    ModeQesc   = 4'd6,
    ModeRx     = 4'd7,
    ModeRxEsc  = 4'd8,
    ModeCls    = 4'd9,
    ModeClsEsc = 4'd10,
    ModeDone   = 4'd11
  } mode_e;

  typedef enum logic [1:0] {
    MoveEmitA = 2'd1,
    MoveDropA = 2'd2,
    MoveDropB = 2'd3
  } move_e;

  typedef struct packed {
    logic [8:0]      a;
    logic [8:0]      b;
    mode_e           mode;
    logic            err;
    logic [8:0]      look;
    logic [3:0][7:0] ebytes;
    logic [2:0]      n;
  } ctx_t;

  localparam logic [8:0] ChLf     = 9'h00A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [8:0] ChSp     = 9'h020;
  localparam logic [8:0] ChBang   = 9'h021;
  localparam logic [8:0] ChDquote = 9'h022;
  localparam logic [8:0] ChDollar = 9'h024;
  localparam logic [8:0] ChAmp    = 9'h026;
  localparam logic [8:0] ChSquote = 9'h027;
  localparam logic [8:0] ChLparen = 9'h028;
  localparam logic [8:0] ChRparen = 9'h029;
  localparam logic [8:0] ChStar   = 9'h02A;
  localparam logic [8:0] ChPlus   = 9'h02B;
  localparam logic [8:0] ChComma  = 9'h02C;
  localparam logic [8:0] ChMinus  = 9'h02D;
  localparam logic [8:0] ChSlash  = 9'h02F;
  localparam logic [8:0] ChColon  = 9'h03A;
  localparam logic [8:0] ChSemi   = 9'h03B;
  localparam logic [8:0] ChEq     = 9'h03D;
  localparam logic [8:0] ChQmark  = 9'h03F;
  localparam logic [8:0] ChLbrack = 9'h05B;
  localparam logic [8:0] ChBslash = 9'h05C;
  localparam logic [8:0] ChRbrack = 9'h05D;
  localparam logic [8:0] ChUscore = 9'h05F;
  localparam logic [8:0] ChBtick  = 9'h060;
  localparam logic [8:0] ChLbrace = 9'h07B;
  localparam logic [8:0] ChBar    = 9'h07C;
  localparam logic [8:0] ChRbrace = 9'h07D;
  localparam logic [8:0] ChTilde  = 9'h07E;
  localparam logic [8:0] ChEnd    = 9'h100;
  localparam logic [8:0] ChNone   = 9'h1FF;

  // Character classes
  function automatic logic is_word(logic [8:0] ch);
    return (ch >= 9'h061 && ch <= 9'h07A) || (ch >= 9'h030 && ch <= 9'h039) ||
           (ch >= 9'h041 && ch <= 9'h05A) || ch == ChUscore || ch == ChDollar ||
           ch == ChBslash || (ch > ChTilde && ch <= 9'h0FF);
  endfunction

  function automatic logic is_quote(logic [8:0] ch);
    return ch == ChSquote || ch == ChDquote || ch == ChBtick;
  endfunction

  function automatic logic opens_regex(logic [8:0] ch);
    return ch == ChLparen || ch == ChComma || ch == ChEq || ch == ChColon ||
           ch == ChLbrack || ch == ChBang || ch == ChAmp || ch == ChBar ||
           ch == ChQmark || ch == ChLbrace || ch == ChRbrace || ch == ChSemi ||
           ch == ChLf;
  endfunction

  // Map control bytes: carriage return to linefeed, linefeed kept, the rest to space
  function automatic logic [8:0] clean(logic [7:0] b);
    if (b >= 8'h20 || b == ChLf[7:0]) begin
      return {1'b0, b};
    end
    if (b == ChCr) begin
      return ChLf;
    end
    return ChSp;
  endfunction

  // Append one character; drop it once four are held
  function automatic ctx_t emit(ctx_t c, logic [8:0] v);
    if (c.n < 3'(MaxEmit)) begin
      c.ebytes[c.n[1:0]] = v[7:0];
      c.n = c.n + 3'd1;
    end
    return c;
  endfunction

  // Decide whether the held pair keeps its space or linefeed
  function automatic move_e pick_move(logic [8:0] a, logic [8:0] b);
    if (a == ChSp) begin
      return is_word(b) ? MoveEmitA : MoveDropA;
    end
    if (a == ChLf) begin
      if (b == ChLbrace || b == ChLbrack || b == ChLparen || b == ChPlus ||
          b == ChMinus) begin
        return MoveEmitA;
      end
      if (b == ChSp) begin
        return MoveDropB;
      end
      return is_word(b) ? MoveEmitA : MoveDropA;
    end
    if (b == ChSp) begin
      return is_word(a) ? MoveEmitA : MoveDropB;
    end
    if (b == ChLf) begin
      if (a == ChRbrace || a == ChRbrack || a == ChRparen || a == ChPlus ||
          a == ChMinus || is_quote(a) || is_word(a)) begin
        return MoveEmitA;
      end
      return MoveDropB;
    end
    return MoveEmitA;
  endfunction

  function automatic ctx_t settle(ctx_t c);
    move_e mv;
    if (c.a == ChEnd) begin
      c.mode = ModeDone;
      return c;
    end
    mv = pick_move(c.a, c.b);
    if (mv == MoveEmitA) begin
      c = emit(c, c.a);
    end
    if (mv != MoveDropB) begin
      c.a = c.b;
      if (is_quote(c.a)) begin
        c = emit(c, c.a);
        c.mode = ModeQuote;
        return c;
      end
    end
    c.mode = ModeFetch;
    return c;
  endfunction

  function automatic ctx_t after_fetch(ctx_t c);
    if (c.b == ChSlash && opens_regex(c.a)) begin
      c = emit(c, c.a);
      c = emit(c, c.b);
      c.mode = ModeRx;
      return c;
    end
    return settle(c);
  endfunction

  function automatic ctx_t fail(ctx_t c);
    c.err  = 1'b1;
    c.a    = ChEnd;
    c.mode = ModeDone;
    return c;
  endfunction

  // One scanner step on one character; may leave a character to scan again
  function automatic ctx_t scan(ctx_t c, logic [8:0] ch);
    c.look = ChNone;
    unique case (c.mode) inside
      ModeFetch: begin
        if (ch == ChSlash) begin
          c.mode = ModeSlash;
        end else begin
          c.b = ch;
          c = after_fetch(c);
        end
      end
      ModeSlash: begin
        if (ch == ChSlash) begin
          c.mode = ModeLine;
        end else if (ch == ChStar) begin
          c.mode = ModeBlock;
        end else begin
          c.b = ChSlash;
          c = after_fetch(c);
          c.look = ch;
        end
      end
      ModeLine: begin
        if (ch == ChLf || ch == ChEnd) begin
          c.b = ch;
          c = after_fetch(c);
        end
      end
      ModeBlock: begin
        if (ch == ChStar) begin
          c.mode = ModeBstar;
        end else if (ch == ChEnd) begin
          c.err = 1'b1;
          c.b = ChEnd;
          c = after_fetch(c);
        end
      end
      ModeBstar: begin
        if (ch == ChSlash) begin
          c.b = ChSp;
          c = after_fetch(c);
        end else begin
          c.mode = ModeBlock;
          c.look = ch;
        end
      end
      ModeQuote: begin
        c.a = ch;
        if (ch == c.b) begin
          c.mode = ModeFetch;
        end else if (ch == ChBslash) begin
          c = emit(c, ch);
          c.mode = ModeQesc;
        end else if (ch == ChEnd) begin
          c = fail(c);
        end else begin
          c = emit(c, ch);
        end
      end
      ModeQesc: begin
        c.a = ch;
        if (ch == ChEnd) begin
          c = fail(c);
        end else begin
          c = emit(c, ch);
          c.mode = ModeQuote;
        end
      end
      ModeRx: begin
        c.a = ch;
        if (ch == ChLbrack) begin
          c = emit(c, ch);
          c.mode = ModeCls;
        end else if (ch == ChSlash) begin
          c.mode = ModeFetch;
        end else if (ch == ChBslash) begin
          c = emit(c, ch);
          c.mode = ModeRxEsc;
        end else if (ch == ChEnd) begin
          c = fail(c);
        end else begin
          c = emit(c, ch);
        end
      end
      ModeRxEsc, ModeClsEsc: begin
        c.a = ch;
        if (ch == ChEnd) begin
          c = fail(c);
        end else begin
          c = emit(c, ch);
          c.mode = (c.mode == ModeRxEsc) ? ModeRx : ModeCls;
        end
      end
      ModeCls: begin
        c.a = ch;
        if (ch == ChRbrack) begin
          c = emit(c, ch);
          c.mode = ModeRx;
        end else if (ch == ChBslash) begin
          c = emit(c, ch);
          c.mode = ModeClsEsc;
        end else if (ch == ChEnd) begin
          c = fail(c);
        end else begin
          c = emit(c, ch);
        end
      end
      default: begin
        c.mode = ModeDone;
      end
    endcase
    return c;
  endfunction

  // Scan a character and at most one character handed back by the first step
  function automatic ctx_t feed(ctx_t c, logic [8:0] ch);
    if (c.mode != ModeDone) begin
      c = scan(c, ch);
    end
    if (c.look != ChNone && c.mode != ModeDone) begin
      c = scan(c, c.look);
    end
    c.look = ChNone;
    return c;
  endfunction

  logic [8:0]      a_q;
  logic [8:0]      b_q;
  mode_e           mode_q;
  logic            err_q;
  logic            end_phase_q;
  logic [3:0][7:0] pend_bytes_q;
  logic [2:0]      pend_n_q;

  ctx_t       ctx_in;
  ctx_t       ctx_out;
  logic [8:0] ch_in;
  logic       live;
  logic       acc;

  // Shared scanner: source byte normally, end marker in the closing cycle
  always_comb begin
    ctx_in      = '0;
    ctx_in.a    = a_q;
    ctx_in.b    = b_q;
    ctx_in.mode = mode_q;
    ctx_in.err  = err_q;
    ctx_in.look = ChNone;
    ch_in       = clean(in_byte_i);
    if (end_phase_q) begin
      ctx_in.ebytes = pend_bytes_q;
      ctx_in.n      = pend_n_q;
      ch_in         = ChEnd;
    end
    ctx_out = feed(ctx_in, ch_in);
  end

  // Accept while no closing cycle is pending and the queue has room
  assign live       = (mode_q != ModeDone);
  assign in_ready_o = !end_phase_q && push_ready_i;
  assign acc        = in_valid_i && in_ready_o;

  // Push a group when characters were released, or the closing group
  assign push_valid_o = end_phase_q ||
                        (acc && live && !in_last_i && (ctx_out.n != 3'd0));
  always_comb begin
    push_data_o       = '0;
    push_data_o.bytes = ctx_out.ebytes;
    push_data_o.count = ctx_out.n;
    push_data_o.last  = end_phase_q;
    push_data_o.err   = ctx_out.err;
  end

  // Hold scanner state; a final byte adds a closing phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q          <= ChLf;
      b_q          <= ChNone;
      mode_q       <= ModeFetch;
      err_q        <= 1'b0;
      end_phase_q  <= 1'b0;
      pend_bytes_q <= '0;
      pend_n_q     <= 3'd0;
    end else if (end_phase_q) begin
      if (push_ready_i) begin
        mode_q      <= ModeDone;
        err_q       <= ctx_out.err;
        end_phase_q <= 1'b0;
      end
    end else if (acc && live) begin
      a_q    <= ctx_out.a;
      b_q    <= ctx_out.b;
      mode_q <= ctx_out.mode;
      err_q  <= ctx_out.err;
      if (in_last_i) begin
        end_phase_q  <= 1'b1;
        pend_bytes_q <= ctx_out.ebytes;
        pend_n_q     <= ctx_out.n;
      end
    end
  end

  // The closing group leaves the scanner finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (end_phase_q && push_ready_i) |=> (mode_q == ModeDone && !end_phase_q))
    else $error("closing group did not finish the scanner");

  // A finished scanner stays finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ModeDone) |=> (mode_q == ModeDone))
    else $error("finished scanner restarted");

  // Error only rises in the closing cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(err_q) |-> $past(end_phase_q))
    else $error("error raised outside the closing cycle");

endmodule

// ===== rtl/core/minjs_queue.sv =====
// Short queue of character groups between the scanner and the output stage.
module minjs_queue
  import minjs_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_valid_i,
  output logic    push_ready_o,
  input  bundle_t push_data_i,
  output logic    pop_valid_o,
  input  logic    pop_ready_i,
  output bundle_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bundle_t         slots_q [Depth];
  logic [PtrW-1:0] wr_q;
  logic [PtrW-1:0] rd_q;
  logic [CntW-1:0] cnt_q;
  logic            push;
  logic            pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = slots_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Store pushed groups
  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_q] <= push_data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // Fill count never passes the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue fill count overflow");

endmodule

// ===== rtl/core/minjs_back.sv =====
// Back end: splits each character group into output items behind an output register.
module minjs_back
  import minjs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    pop_valid_i,
  output logic    pop_ready_o,
  input  bundle_t pop_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  logic [1:0] idx_q;
  logic       ov_q;
  result_t    res_q;
  logic [2:0] nres;
  logic       is_final;
  logic       load;
  logic       take;

  // An empty closing group still yields one item
  assign nres     = (pop_data_i.count == 3'd0) ? 3'd1 : pop_data_i.count;
  assign is_final = ({1'b0, idx_q} == (nres - 3'd1));
  assign load     = !ov_q || out_ready_i;
  assign take     = load && pop_valid_i;
  assign pop_ready_o = take && is_final;

  assign out_valid_o = ov_q;
  assign out_data_o  = res_q;

  // Load the next item of the head group; drop the group after its last item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      idx_q <= 2'd0;
      res_q <= '0;
    end else if (load) begin
      ov_q <= pop_valid_i;
      if (pop_valid_i) begin
        res_q.out_byte   <= pop_data_i.bytes[idx_q];
        res_q.byte_valid <= (pop_data_i.count != 3'd0);
        res_q.run_last   <= is_final;
        res_q.stream_end <= is_final && pop_data_i.last;
        res_q.err        <= pop_data_i.err;
        idx_q            <= is_final ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  // Groups never hold more than four characters
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_valid_i |-> (pop_data_i.count <= 3'(MaxEmit)))
    else $error("character group too large");

  // Partway through a group its remaining items are still queued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != 2'd0) |-> pop_valid_i)
    else $error("group left before its last item");

endmodule

// ===== rtl/core/javascript_minifier_top.sv =====
// Latency: an accepted item's results pass the group queue and then the output register;
// a final item adds a closing phase to scan the end of source.
// Throughput: one item per cycle while each yields at most one result and the queue
// has room; an item with several results holds the output until all are sent, and a QueueDepth-group queue
// lets the scanner keep accepting meanwhile. The scanner's closing phase blocks input.
// Reset: asynchronous, clears scanner to fetch mode with a held linefeed; no clearing pass.
module javascript_minifier_top
  import minjs_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // in_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [8] stream_end, [9] error
  output logic        m_axis_tuser,   // byte_valid
  output logic        m_axis_tlast    // run_last
);

  logic    push_valid;
  logic    push_ready;
  bundle_t push_data;
  logic    pop_valid;
  logic    pop_ready;
  bundle_t pop_data;
  result_t res;

  minjs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  minjs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  minjs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res)
  );

  // Pack result fields onto the stream
  assign m_axis_tdata = {6'b0, res.err, res.stream_end, res.out_byte};
  assign m_axis_tuser = res.byte_valid;
  assign m_axis_tlast = res.run_last;

endmodule

// ===== dv/tb_javascript_minifier_top.sv =====
// Self-checking testbench for the JavaScript minifier: source bytes in, minified items checked.
module tb_javascript_minifier_top;
  timeunit 1ns;
  timeprecision 1ps;

  import minjs_pkg::*;

  localparam logic [8:0] CharEnd   = 9'h100;
  localparam logic [8:0] CharNone  = 9'h1FF;
  localparam logic [8:0] CharLf    = 9'h00A;
  localparam logic [8:0] CharSpace = 9'h020;
  localparam logic [7:0] Backtick  = 8'h60;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned SourceLen = 470;

  typedef enum logic [3:0] {
    ScanFetch, ScanSlash, ScanLine, ScanBlock, ScanBlockStar, ScanQuote, ScanQuoteEsc,
    ScanRegex, ScanRegexEsc, ScanClass, ScanClassEsc, ScanDone
  } scan_mode_e;

  typedef enum logic [1:0] {KeepCur, DropCur, DropNext} move_e;

  // Predicts the minified stream and holds the items still owed by the block
  class minify_scoreboard;
    logic [8:0]  cur_ch;
    logic [8:0]  next_ch;
    logic [8:0]  rescan_ch;
    scan_mode_e  mode;
    bit          err_seen;
    logic [7:0]  released[$];
    result_t     owed_results[$];
    int unsigned mismatches;

    function new();
      cur_ch     = CharLf;
      next_ch    = CharNone;
      rescan_ch  = CharNone;
      mode       = ScanFetch;
      err_seen   = 1'b0;
      mismatches = 0;
    endfunction

    static function bit is_word(logic [8:0] c);
      return (c >= "a" && c <= "z") || (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
             c == "_" || c == "$" || c == "\\" || (c > 9'd126 && c <= 9'd255);
    endfunction

    static function bit is_quote(logic [8:0] c);
      return c == 9'h027 || c == 9'h022 || c == {1'b0, Backtick};
    endfunction

    static function bit opens_regex(logic [8:0] c);
      return c inside {"(", ",", "=", ":", "[", "!", "&", "|", "?", "{", "}", ";", CharLf};
    endfunction

    static function logic [8:0] clean(logic [7:0] b);
      if (b >= 8'h20 || b == 8'h0A) return {1'b0, b};
      if (b == 8'h0D) return CharLf;
      return CharSpace;
    endfunction

    function void release_ch(logic [8:0] c);
      if (released.size() < MaxEmit) released.push_back(c[7:0]);
    endfunction

    // Keep a blank only where both neighbors need it
    function move_e pick_move();
      if (cur_ch == CharSpace) return is_word(next_ch) ? KeepCur : DropCur;
      if (cur_ch == CharLf) begin
        if (next_ch inside {"{", "[", "(", "+", "-"}) return KeepCur;
        if (next_ch == CharSpace) return DropNext;
        return is_word(next_ch) ? KeepCur : DropCur;
      end
      if (next_ch == CharSpace) return is_word(cur_ch) ? KeepCur : DropNext;
      if (next_ch == CharLf) begin
        if (cur_ch inside {"}", "]", ")", "+", "-"} || is_quote(cur_ch) || is_word(cur_ch))
          return KeepCur;
        return DropNext;
      end
      return KeepCur;
    endfunction

    function void settle();
      move_e mv;
      if (cur_ch == CharEnd) begin
        mode = ScanDone;
        return;
      end
      mv = pick_move();
      if (mv == KeepCur) release_ch(cur_ch);
      if (mv != DropNext) begin
        cur_ch = next_ch;
        if (is_quote(cur_ch)) begin
          release_ch(cur_ch);
          mode = ScanQuote;
          return;
        end
      end
      mode = ScanFetch;
    endfunction

    function void after_fetch();
      if (next_ch == "/" && opens_regex(cur_ch)) begin
        release_ch(cur_ch);
        release_ch(next_ch);
        mode = ScanRegex;
        return;
      end
      settle();
    endfunction

    function void abort();
      err_seen = 1'b1;
      cur_ch   = CharEnd;
      mode     = ScanDone;
    endfunction

    // Advance the mode machine by one character
    function void scan(logic [8:0] ch);
      case (mode)
        ScanFetch: begin
          if (ch == "/") mode = ScanSlash;
          else begin
            next_ch = ch;
            after_fetch();
          end
        end
        ScanSlash: begin
          if (ch == "/") mode = ScanLine;
          else if (ch == "*") mode = ScanBlock;
          else begin
            next_ch = "/";
            after_fetch();
            rescan_ch = ch;
          end
        end
        ScanLine: begin
          if (ch == CharLf || ch == CharEnd) begin
            next_ch = ch;
            after_fetch();
          end
        end
        ScanBlock: begin
          if (ch == "*") mode = ScanBlockStar;
          else if (ch == CharEnd) begin
            err_seen = 1'b1;
            next_ch  = CharEnd;
            after_fetch();
          end
        end
        ScanBlockStar: begin
          if (ch == "/") begin
            next_ch = CharSpace;
            after_fetch();
          end else begin
            mode      = ScanBlock;
            rescan_ch = ch;
          end
        end
        ScanQuote: begin
          cur_ch = ch;
          if (ch == next_ch) mode = ScanFetch;
          else if (ch == "\\") begin
            release_ch(ch);
            mode = ScanQuoteEsc;
          end else if (ch == CharEnd) abort();
          else release_ch(ch);
        end
        ScanQuoteEsc: begin
          cur_ch = ch;
          if (ch == CharEnd) abort();
          else begin
            release_ch(ch);
            mode = ScanQuote;
          end
        end
        ScanRegex: begin
          cur_ch = ch;
          if (ch == "[") begin
            release_ch(ch);
            mode = ScanClass;
          end else if (ch == "/") mode = ScanFetch;
          else if (ch == "\\") begin
            release_ch(ch);
            mode = ScanRegexEsc;
          end else if (ch == CharEnd) abort();
          else release_ch(ch);
        end
        ScanRegexEsc, ScanClassEsc: begin
          cur_ch = ch;
          if (ch == CharEnd) abort();
          else begin
            release_ch(ch);
            mode = (mode == ScanRegexEsc) ? ScanRegex : ScanClass;
          end
        end
        ScanClass: begin
          cur_ch = ch;
          if (ch == "]") begin
            release_ch(ch);
            mode = ScanRegex;
          end else if (ch == "\\") begin
            release_ch(ch);
            mode = ScanClassEsc;
          end else if (ch == CharEnd) abort();
          else release_ch(ch);
        end
        default: mode = ScanDone;
      endcase
    endfunction

    // Scan one character plus any character handed back for a second look
    function void feed(logic [8:0] ch);
      logic [8:0] c;
      int g;
      rescan_ch = ch;
      for (g = 0; g < 4 && rescan_ch != CharNone; g++) begin
        c         = rescan_ch;
        rescan_ch = CharNone;
        if (mode != ScanDone) scan(c);
      end
      rescan_ch = CharNone;
    endfunction

    // Note an accepted source byte and queue the items it releases
    function void note_input(logic [7:0] b, bit closes);
      bit      ended;
      int      n;
      int      g;
      int      k;
      result_t r;
      ended = 1'b0;
      if (mode == ScanDone) return;
      released.delete();
      feed(clean(b));
      if (closes) begin
        for (g = 0; g < 8 && mode != ScanDone; g++) feed(CharEnd);
        mode  = ScanDone;
        ended = 1'b1;
      end
      n = released.size();
      for (k = 0; k < n; k++) begin
        r.out_byte   = released[k];
        r.byte_valid = 1'b1;
        r.run_last   = (k == n - 1);
        r.stream_end = ended && (k == n - 1);
        r.err        = err_seen;
        owed_results.push_back(r);
      end
      // An empty closing step still reports the end of the stream
      if (ended && n == 0) begin
        r.out_byte   = 8'h00;
        r.byte_valid = 1'b0;
        r.run_last   = 1'b1;
        r.stream_end = 1'b1;
        r.err        = err_seen;
        owed_results.push_back(r);
      end
    endfunction

    // Compare an output item with the oldest one owed
    function void check_result(result_t got);
      result_t want;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output item: byte %02h valid %0b last %0b end %0b err %0b",
                   got.out_byte, got.byte_valid, got.run_last, got.stream_end, got.err);
        return;
      end
      want = owed_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("output mismatch: expected %02h/%0b/%0b/%0b/%0b got %02h/%0b/%0b/%0b/%0b",
                   want.out_byte, want.byte_valid, want.run_last, want.stream_end, want.err,
                   got.out_byte, got.byte_valid, got.run_last, got.stream_end, got.err);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] in_byte
  logic        s_axis_tlast  = 1'b0;   // in_last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [7:0] out_byte, [8] stream_end, [9] error
  logic        m_axis_tuser;           // byte_valid
  logic        m_axis_tlast;           // run_last

  minify_scoreboard sb = new();
  logic [7:0]       source_bytes[$];
  int unsigned      bytes_in  = 0;
  int unsigned      idle_cycles = 0;
  bit               rx_hold   = 1'b0;
  bit               hold_done = 1'b0;

  javascript_minifier_top i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Source text generation
  function automatic void add_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) source_bytes.push_back(s[i]);
  endfunction

  function automatic logic [7:0] word_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 8'("a" + $urandom_range(0, 25));
      5:             return 8'("A" + $urandom_range(0, 25));
      6:             return 8'("0" + $urandom_range(0, 9));
      7:             return "_";
      8:             return "$";
      default:       return 8'($urandom_range(127, 255));
    endcase
  endfunction

  // Printable or high byte that cannot open or close anything
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(32, 255));
    while (c inside {"/", "\\", "[", "]", "*", 8'h27, 8'h22, Backtick});
    return c;
  endfunction

  function automatic logic [7:0] quote_char();
    case ($urandom_range(0, 2))
      0:       return 8'h27;
      1:       return 8'h22;
      default: return Backtick;
    endcase
  endfunction

  // Append one token of mostly well-formed source
  function automatic void add_token();
    string      ops;
    string      openers;
    logic [7:0] q;
    logic [7:0] c;
    ops     = "+-*=<>!&|?:;,.(){}[]%^~";
    openers = "(,=:[!&|?{};";
    case ($urandom_range(0, 19))
      0, 1, 2, 3: repeat ($urandom_range(1, 6)) source_bytes.push_back(word_char());
      4: repeat ($urandom_range(1, 4)) source_bytes.push_back(8'("0" + $urandom_range(0, 9)));
      5, 6, 7: source_bytes.push_back(ops[$urandom_range(0, ops.len() - 1)]);
      8, 9, 10: begin
        case ($urandom_range(0, 5))
          0: add_text(" ");
          1: source_bytes.push_back(8'h09);
          2: source_bytes.push_back(8'h0A);
          3: source_bytes.push_back(8'h0D);
          4: begin
            source_bytes.push_back(8'h0D);
            source_bytes.push_back(8'h0A);
          end
          default: source_bytes.push_back(8'($urandom_range(0, 31)));
        endcase
      end
      11, 12: begin
        q = quote_char();
        source_bytes.push_back(q);
        repeat ($urandom_range(0, 8)) begin
          if ($urandom_range(0, 4) == 0) begin
            source_bytes.push_back("\\");
            source_bytes.push_back(8'($urandom_range(0, 255)));
          end else source_bytes.push_back(plain_char());
        end
        source_bytes.push_back(q);
      end
      13, 14: begin
        if ($urandom_range(0, 5) == 0) source_bytes.push_back(8'h0A);
        else source_bytes.push_back(openers[$urandom_range(0, openers.len() - 1)]);
        source_bytes.push_back("/");
        source_bytes.push_back(word_char());
        repeat ($urandom_range(0, 5)) begin
          case ($urandom_range(0, 3))
            0, 1: source_bytes.push_back(plain_char());
            2: begin
              source_bytes.push_back("\\");
              source_bytes.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
              source_bytes.push_back("[");
              repeat ($urandom_range(0, 3)) begin
                if ($urandom_range(0, 2) == 0) begin
                  source_bytes.push_back("\\");
                  source_bytes.push_back(8'($urandom_range(0, 255)));
                end else source_bytes.push_back(plain_char());
              end
              source_bytes.push_back("]");
            end
          endcase
        end
        source_bytes.push_back("/");
        if ($urandom_range(0, 1) == 0) source_bytes.push_back("g");
      end
      15: begin
        add_text("//");
        repeat ($urandom_range(0, 6)) source_bytes.push_back(plain_char());
        source_bytes.push_back($urandom_range(0, 1) ? 8'h0A : 8'h0D);
      end
      16: begin
        add_text("/*");
        repeat ($urandom_range(0, 8))
          source_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'("*") : plain_char());
        add_text("*/");
      end
      17: begin
        source_bytes.push_back(word_char());
        source_bytes.push_back("/");
        source_bytes.push_back(word_char());
      end
      18: begin
        // noise that never opens a comment, string or regex
        do c = 8'($urandom_range(0, 255));
        while (c inside {"/", 8'h27, 8'h22, Backtick});
        source_bytes.push_back(c);
      end
      default: repeat ($urandom_range(1, 4)) source_bytes.push_back(8'($urandom_range(128, 255)));
    endcase
  endfunction

  // Close the stream in one of its possible ways
  function automatic void add_ending();
    case ($urandom_range(0, 6))
      0: source_bytes.push_back(word_char());
      1: begin
        // trailing blanks leave the closing step with nothing to emit
        source_bytes.push_back(word_char());
        add_text("  ");
      end
      2: add_text("/* ab");
      3: begin
        source_bytes.push_back(quote_char());
        add_text("ab");
      end
      4: add_text(";/ab");
      5: add_text("// ab");
      default: begin
        source_bytes.push_back(quote_char());
        add_text("a\\");
      end
    endcase
  endfunction

  // Offer one item and hold it until accepted; return at the next falling edge
  task automatic drive_byte(input logic [7:0] b, input bit closes);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= closes;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(b, closes);
    bytes_in++;
    @(negedge clk_i);
  endtask

  // Send the source in bursts, then a few items past the end of stream
  task automatic send_source();
    int unsigned burst_left;
    int          i;
    burst_left = 0;
    for (i = 0; i < source_bytes.size(); i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if (!rx_hold && $urandom_range(0, 3) != 0) begin
          s_axis_tvalid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(negedge clk_i);
        end
      end
      burst_left--;
      drive_byte(source_bytes[i], i == source_bytes.size() - 1);
    end
    repeat (3) drive_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    s_axis_tvalid <= 1'b0;
  endtask

  // Receiver: stall in phases of random style, with one long hold-off
  initial begin
    int unsigned style;
    int unsigned span;
    forever begin
      style = $urandom_range(0, 3);
      span  = $urandom_range(16, 120);
      if (!hold_done && bytes_in >= 120) begin
        rx_hold = 1'b1;
        @(negedge clk_i) m_axis_tready <= 1'b0;
        repeat (150) @(negedge clk_i);
        rx_hold   = 1'b0;
        hold_done = 1'b1;
      end else begin
        repeat (span) begin
          @(negedge clk_i);
          case (style)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= ($urandom_range(0, 7) != 0);
          endcase
        end
      end
    end
  end

  // Check every accepted output item
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result('{out_byte: m_axis_tdata[7:0], byte_valid: m_axis_tuser,
                        run_last: m_axis_tlast, stream_end: m_axis_tdata[8],
                        err: m_axis_tdata[9]});
  end

  // Stop a run that makes no progress
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    // directed opening: control and high bytes, comments, regex class, escapes, template
    source_bytes.push_back(8'h00);
    source_bytes.push_back(8'hFF);
    add_text(" a");
    source_bytes.push_back(8'h0D);
    source_bytes.push_back(8'h0A);
    add_text("{");
    source_bytes.push_back(8'h09);
    add_text("/**x*/}//");
    source_bytes.push_back(8'h7F);
    source_bytes.push_back(8'h0A);
    add_text("=/[\\]/]/\"\\\"\"");
    source_bytes.push_back(Backtick);
    source_bytes.push_back(8'h0A);
    source_bytes.push_back(Backtick);
    add_text(";");
    while (source_bytes.size() < SourceLen) add_token();
    add_ending();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_source();

    // Drain what is still owed, then let the pipeline settle
    while (sb.owed_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.owed_results.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/minjs_pkg.sv
rtl/core/minjs_front.sv
rtl/core/minjs_queue.sv
rtl/core/minjs_back.sv
rtl/core/javascript_minifier_top.sv
dv/tb_javascript_minifier_top.sv
